/* src/gptdc_pkg.sv */
package gptdc_pkg;

  localparam int DW = 40;
  localparam int ZW = 34;
  localparam int HW = 35;
  localparam int TABLE_LEN = 24;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic [15:0] PAN_MAX = 16'd51472;
  localparam logic [15:0] TILT_MAX = 16'd25736;

  localparam logic [2:0] REG_AXIS_X = 3'd0;
  localparam logic [2:0] REG_AXIS_Y = 3'd1;
  localparam logic [2:0] REG_AXIS_Z = 3'd2;
  localparam logic [2:0] REG_ORIGIN = 3'd3;
  localparam logic [2:0] REG_PAN_TOL = 3'd4;
  localparam logic [2:0] REG_TILT_TOL = 3'd5;
  localparam logic [2:0] REG_COST_SCALE = 3'd6;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
  } in_t;

  typedef struct packed {
    logic [15:0] visibility_cost;
    logic [15:0] pan_excess;
    logic [14:0] tilt_excess;
  } out_t;

  typedef struct packed {
    logic [47:0] head_axis_x;
    logic [47:0] head_axis_y;
    logic [47:0] head_axis_z;
    logic [47:0] head_origin;
    logic [14:0] pan_half_tolerance;
    logic [14:0] tilt_half_tolerance;
    logic [15:0] cost_scale;
  } cfg_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    case (idx)
      0:  return 34'sh3243F6A8;
      1:  return 34'sh1DAC6705;
      2:  return 34'sh0FADBAFC;
      3:  return 34'sh07F56EA6;
      4:  return 34'sh03FEAB76;
      5:  return 34'sh01FFD55B;
      6:  return 34'sh00FFFAAA;
      7:  return 34'sh007FFF55;
      8:  return 34'sh003FFFEA;
      9:  return 34'sh001FFFFD;
      10: return 34'sh000FFFFF;
      11: return 34'sh0007FFFF;
      12: return 34'sh0003FFFF;
      13: return 34'sh0001FFFF;
      14: return 34'sh0000FFFF;
      15: return 34'sh00007FFF;
      16: return 34'sh00003FFF;
      17: return 34'sh00001FFF;
      18: return 34'sh00000FFF;
      19: return 34'sh000007FF;
      20: return 34'sh000003FF;
      21: return 34'sh000001FF;
      22: return 34'sh000000FF;
      23: return 34'sh0000007F;
      default: return '0;
    endcase
  endfunction

  function automatic logic [15:0] angle_q14(input logic signed [ZW-1:0] z,
                                            input logic [15:0] maxv);
    logic [ZW-1:0] a;
    if (z < 0) begin
      return 16'd0;
    end
    a = (unsigned'(z) + ZW'(32768)) >> 16;
    if (a > ZW'(maxv)) begin
      return maxv;
    end
    return a[15:0];
  endfunction

endpackage

/* src/gptdc_xform.sv */
module gptdc_xform import gptdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  in_t                  in_point,
  input  cfg_t                 cfg,
  output logic                 out_vld,
  output logic signed [HW-1:0] out_hx,
  output logic signed [HW-1:0] out_hy,
  output logic signed [HW-1:0] out_hz
);

  logic [2:0] vld_r;
  logic signed [16:0] d_r [3];
  logic signed [16:0] d_nxt [3];
  logic signed [32:0] prod_r [9];
  logic signed [32:0] prod_nxt [9];
  logic signed [HW-1:0] h_r [3];
  logic signed [HW-1:0] h_nxt [3];
  logic [47:0] axes [3];
  logic signed [15:0] pt [3];

  assign axes[0] = cfg.head_axis_x;
  assign axes[1] = cfg.head_axis_y;
  assign axes[2] = cfg.head_axis_z;
  assign pt[0] = in_point.point_x;
  assign pt[1] = in_point.point_y;
  assign pt[2] = in_point.point_z;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_nxt[j] = 17'(pt[j]) - 17'(signed'(cfg.head_origin[16*j +: 16]));
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[3*r+k] = 33'(signed'(axes[r][16*k +: 16])) * 33'(d_r[k]);
      end
    end
    for (int r = 0; r < 3; r++) begin
      h_nxt[r] = HW'(prod_r[3*r]) + HW'(prod_r[3*r+1]) + HW'(prod_r[3*r+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
      prod_r <= prod_nxt;
      h_r <= h_nxt;
    end
  end

  assign out_vld = vld_r[2];
  assign out_hx = h_r[0];
  assign out_hy = h_r[1];
  assign out_hz = h_r[2];

endmodule

/* src/gptdc_cordic.sv */
module gptdc_cordic import gptdc_pkg::*; #(
  parameter int STEPS = 16,
  parameter int SIDE_W = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [DW-1:0] in_x,
  input  logic signed [DW-1:0] in_y,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_vld,
  output logic signed [DW-1:0] out_x,
  output logic signed [ZW-1:0] out_z,
  output logic [SIDE_W-1:0]    out_side
);

  logic                 vld_r  [0:STEPS];
  logic                 zero_r [0:STEPS];
  logic signed [DW-1:0] x_r    [0:STEPS];
  logic signed [DW-1:0] y_r    [0:STEPS];
  logic signed [ZW-1:0] z_r    [0:STEPS];
  logic [SIDE_W-1:0]    side_r [0:STEPS];
  logic signed [DW-1:0] y_abs;

  assign y_abs = (in_y < 0) ? -in_y : in_y;

  // quadrant fold and zero-vector detect
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (in_x == '0) && (in_y == '0);
      side_r[0] <= in_side;
      if (in_x < 0) begin
        x_r[0] <= y_abs;
        y_r[0] <= -in_x;
        z_r[0] <= HALF_PI_Q30;
      end else begin
        x_r[0] <= in_x;
        y_r[0] <= y_abs;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [DW-1:0] x_nxt;
    logic signed [DW-1:0] y_nxt;
    logic signed [ZW-1:0] z_nxt;

    always_comb begin
      if (y_r[i] >= 0) begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + atan_q30(i);
      end else begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - atan_q30(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
        zero_r[i+1] <= zero_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_vld = vld_r[STEPS];
  assign out_x = x_r[STEPS];
  assign out_z = zero_r[STEPS] ? '0 : z_r[STEPS];
  assign out_side = side_r[STEPS];

endmodule

/* src/gptdc_gain.sv */
module gptdc_gain import gptdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [DW-1:0] in_mag,
  input  logic signed [ZW-1:0] in_pan_z,
  input  logic signed [HW-1:0] in_hz,
  output logic                 out_vld,
  output logic signed [DW-1:0] out_x,
  output logic signed [DW-1:0] out_y,
  output logic [15:0]          out_pan
);

  localparam int PW = DW + 16;

  logic [1:0]           vld_r;
  logic [PW-1:0]        prod_r;
  logic [15:0]          pan1_r;
  logic [15:0]          pan2_r;
  logic [HW-1:0]        hz1_r;
  logic [HW-1:0]        hz2_r;
  logic [DW-1:0]        hyp_r;
  logic [PW-1:0]        hyp_nxt;

  assign hyp_nxt = (prod_r + PW'(32768)) >> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(unsigned'(in_mag)) * PW'(INV_GAIN_Q16);
      pan1_r <= angle_q14(in_pan_z, PAN_MAX);
      hz1_r <= unsigned'((in_hz < 0) ? -in_hz : in_hz);
      hyp_r <= hyp_nxt[DW-1:0];
      pan2_r <= pan1_r;
      hz2_r <= hz1_r;
    end
  end

  assign out_vld = vld_r[1];
  assign out_x = signed'(hyp_r);
  assign out_y = signed'(DW'(hz2_r));
  assign out_pan = pan2_r;

endmodule

/* src/gptdc_cost.sv */
module gptdc_cost import gptdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [15:0]          in_pan,
  input  logic signed [ZW-1:0] in_tilt_z,
  input  cfg_t                 cfg,
  output logic                 out_vld,
  output out_t                 out_data
);

  logic [3:0]  vld_r;
  logic [15:0] pan_r;
  logic [15:0] tilt_r;
  logic [15:0] pex_r;
  logic [15:0] tex_r;
  logic [16:0] sum_r;
  logic [15:0] pex2_r;
  logic [15:0] tex2_r;
  logic [32:0] prod_r;
  logic [15:0] pex_nxt;
  logic [15:0] tex_nxt;
  logic [32:0] round_nxt;
  out_t        out_r;

  assign pex_nxt = (pan_r > 16'(cfg.pan_half_tolerance)) ?
                   pan_r - 16'(cfg.pan_half_tolerance) : 16'd0;
  assign tex_nxt = (tilt_r > 16'(cfg.tilt_half_tolerance)) ?
                   tilt_r - 16'(cfg.tilt_half_tolerance) : 16'd0;
  assign round_nxt = (prod_r + 33'(32768)) >> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pan_r <= in_pan;
      tilt_r <= angle_q14(in_tilt_z, TILT_MAX);
      pex_r <= pex_nxt;
      tex_r <= tex_nxt;
      sum_r <= 17'(pex_nxt) + 17'(tex_nxt);
      pex2_r <= pex_r;
      tex2_r <= tex_r;
      prod_r <= 33'(sum_r) * 33'(cfg.cost_scale);
      out_r.visibility_cost <= (round_nxt > 33'(16'hFFFF)) ? 16'hFFFF : round_nxt[15:0];
      out_r.pan_excess <= pex2_r;
      out_r.tilt_excess <= tex2_r[14:0];
    end
  end

  assign out_vld = vld_r[3];
  assign out_data = out_r;

endmodule

/* src/gaze_pan_tilt_deadzone_cost_top.sv */
// Visibility cost of a workspace point for the head pose held in the registers. The block
// takes one point per cycle while the output is not stalled and returns one result per
// point, in order, through three frame-transform stages, two chains of one register stage
// per CORDIC step, min(CORDIC_STEPS,24) steps (pan, then tilt), each with a fold stage, two gain stages
// and four cost stages. A stalled result holds the whole pipeline. Registers sit at byte
// address 8*index on the 64-bit config port and may be written only while the block is idle.
module gaze_pan_tilt_deadzone_cost_top import gptdc_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  cfg_t cfg_r;
  logic en;
  logic [2:0] reg_idx;

  logic                 xf_vld;
  logic signed [HW-1:0] xf_hx;
  logic signed [HW-1:0] xf_hy;
  logic signed [HW-1:0] xf_hz;
  logic                 pan_vld;
  logic signed [DW-1:0] pan_mag;
  logic signed [ZW-1:0] pan_z;
  logic [HW-1:0]        pan_side;
  logic                 gn_vld;
  logic signed [DW-1:0] gn_x;
  logic signed [DW-1:0] gn_y;
  logic [15:0]          gn_pan;
  logic                 tl_vld;
  logic signed [DW-1:0] tl_mag;
  logic signed [ZW-1:0] tl_z;
  logic [15:0]          tl_pan;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign pready = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_axis_x <= 48'd16384;
      cfg_r.head_axis_y <= 48'd1073741824;
      cfg_r.head_axis_z <= 48'd70368744177664;
      cfg_r.head_origin <= '0;
      cfg_r.pan_half_tolerance <= 15'd2458;
      cfg_r.tilt_half_tolerance <= 15'd2458;
      cfg_r.cost_scale <= 16'd33704;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_AXIS_X:     cfg_r.head_axis_x <= pwdata[47:0];
        REG_AXIS_Y:     cfg_r.head_axis_y <= pwdata[47:0];
        REG_AXIS_Z:     cfg_r.head_axis_z <= pwdata[47:0];
        REG_ORIGIN:     cfg_r.head_origin <= pwdata[47:0];
        REG_PAN_TOL:    cfg_r.pan_half_tolerance <= pwdata[14:0];
        REG_TILT_TOL:   cfg_r.tilt_half_tolerance <= pwdata[14:0];
        REG_COST_SCALE: cfg_r.cost_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_AXIS_X:     prdata = 64'(cfg_r.head_axis_x);
      REG_AXIS_Y:     prdata = 64'(cfg_r.head_axis_y);
      REG_AXIS_Z:     prdata = 64'(cfg_r.head_axis_z);
      REG_ORIGIN:     prdata = 64'(cfg_r.head_origin);
      REG_PAN_TOL:    prdata = 64'(cfg_r.pan_half_tolerance);
      REG_TILT_TOL:   prdata = 64'(cfg_r.tilt_half_tolerance);
      REG_COST_SCALE: prdata = 64'(cfg_r.cost_scale);
      default:        prdata = '0;
    endcase
  end

  gptdc_xform u_xform (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_valid), .in_point(in_data), .cfg(cfg_r),
    .out_vld(xf_vld), .out_hx(xf_hx), .out_hy(xf_hy), .out_hz(xf_hz)
  );

  gptdc_cordic #(.STEPS(STEPS), .SIDE_W(HW)) u_pan (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(xf_vld), .in_x(DW'(xf_hx)), .in_y(DW'(xf_hy)), .in_side(unsigned'(xf_hz)),
    .out_vld(pan_vld), .out_x(pan_mag), .out_z(pan_z), .out_side(pan_side)
  );

  gptdc_gain u_gain (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(pan_vld), .in_mag(pan_mag), .in_pan_z(pan_z), .in_hz(signed'(pan_side)),
    .out_vld(gn_vld), .out_x(gn_x), .out_y(gn_y), .out_pan(gn_pan)
  );

  gptdc_cordic #(.STEPS(STEPS), .SIDE_W(16)) u_tilt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(gn_vld), .in_x(gn_x), .in_y(gn_y), .in_side(gn_pan),
    .out_vld(tl_vld), .out_x(tl_mag), .out_z(tl_z), .out_side(tl_pan)
  );

  gptdc_cost u_cost (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(tl_vld), .in_pan(tl_pan), .in_tilt_z(tl_z), .cfg(cfg_r),
    .out_vld(out_valid), .out_data(out_data)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pan_excess <= PAN_MAX) && (15'(TILT_MAX) >= out_data.tilt_excess))
    else $error("excess above angle clamp");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.pan_excess == '0 && out_data.tilt_excess == '0)
      |-> out_data.visibility_cost == '0)
    else $error("nonzero cost with no excess");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall)
      |=> (out_valid && $stable(out_data) && $stable(tl_z) && $stable(tl_mag)))
    else $error("pipeline moved under stall");

endmodule

/* tb/sv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gptdc_pkg::*;

  localparam int STEPS = 16;
  localparam int LATENCY = 2 * STEPS + 11;
  localparam int LIMIT = 400000;
  localparam longint ATAN_TAB [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  cfg_t pose;
  out_t cost_queue[$];
  int errors = 0;
  int cycles = 0;
  bit stall_hold = 0;

  gaze_pan_tilt_deadzone_cost_top #(.CORDIC_STEPS(STEPS)) dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic longint sx16(logic [47:0] v, int k);
    return longint'(signed'(v[16*k +: 16]));
  endfunction

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint vector_angle(longint x, longint y, output longint mag);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 1686629713;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint angle_to_q14(longint z, longint maxv);
    longint a;
    if (z < 0) return 0;
    a = (z + 32768) >>> 16;
    return a > maxv ? maxv : a;
  endfunction

  function automatic out_t predict_cost(in_t p);
    longint d[3], hx, hy, hz, rs, unused, pan, tilt, pex, tex, cost, r;
    out_t o;
    d[0] = longint'(p.point_x) - sx16(pose.head_origin, 0);
    d[1] = longint'(p.point_y) - sx16(pose.head_origin, 1);
    d[2] = longint'(p.point_z) - sx16(pose.head_origin, 2);
    hx = sx16(pose.head_axis_x, 0) * d[0] + sx16(pose.head_axis_x, 1) * d[1]
         + sx16(pose.head_axis_x, 2) * d[2];
    hy = sx16(pose.head_axis_y, 0) * d[0] + sx16(pose.head_axis_y, 1) * d[1]
         + sx16(pose.head_axis_y, 2) * d[2];
    hz = sx16(pose.head_axis_z, 0) * d[0] + sx16(pose.head_axis_z, 1) * d[1]
         + sx16(pose.head_axis_z, 2) * d[2];
    pan = angle_to_q14(vector_angle(hx, hy < 0 ? -hy : hy, rs), 51472);
    r = (rs * 39797 + 32768) >>> 16;
    tilt = angle_to_q14(vector_angle(r, hz < 0 ? -hz : hz, unused), 25736);
    pex = pan > pose.pan_half_tolerance ? pan - pose.pan_half_tolerance : 0;
    tex = tilt > pose.tilt_half_tolerance ? tilt - pose.tilt_half_tolerance : 0;
    cost = ((pex + tex) * pose.cost_scale + 32768) >>> 16;
    if (cost > 65535) cost = 65535;
    o.visibility_cost = cost[15:0];
    o.pan_excess = pex[15:0];
    o.tilt_excess = tex[14:0];
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // result side
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (cost_queue.size() == 0) begin
          report("unexpected result", longint'(out_data), 0);
        end else begin
          want = cost_queue.pop_front();
          if (out_data.visibility_cost !== want.visibility_cost)
            report("visibility_cost", longint'(out_data.visibility_cost),
                   longint'(want.visibility_cost));
          if (out_data.pan_excess !== want.pan_excess)
            report("pan_excess", longint'(out_data.pan_excess), longint'(want.pan_excess));
          if (out_data.tilt_excess !== want.tilt_excess)
            report("tilt_excess", longint'(out_data.tilt_excess),
                   longint'(want.tilt_excess));
        end
      end
      if (stall_hold) out_stall <= 0;
      else if (cycles % 97 < 40) out_stall <= 0;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
    case (idx)
      REG_AXIS_X: pose.head_axis_x = value[47:0];
      REG_AXIS_Y: pose.head_axis_y = value[47:0];
      REG_AXIS_Z: pose.head_axis_z = value[47:0];
      REG_ORIGIN: pose.head_origin = value[47:0];
      REG_PAN_TOL: pose.pan_half_tolerance = value[14:0];
      REG_TILT_TOL: pose.tilt_half_tolerance = value[14:0];
      REG_COST_SCALE: pose.cost_scale = value[15:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (cost_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_point(in_t p, bit check_fixed, out_t fixed);
    out_t o;
    in_valid <= 1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    o = predict_cost(p);
    if (check_fixed && o !== fixed) report("directed row", longint'(o), longint'(fixed));
    cost_queue = {cost_queue, o};
  endtask

  function automatic in_t mk(int x, int y, int z);
    in_t p;
    p.point_x = 16'(x); p.point_y = 16'(y); p.point_z = 16'(z);
    return p;
  endfunction

  function automatic out_t res(int c, int pe, int te);
    out_t o;
    o.visibility_cost = 16'(c); o.pan_excess = 16'(pe); o.tilt_excess = 15'(te);
    return o;
  endfunction

  function automatic logic [47:0] rand_axis();
    return {16'($urandom_range(0, 32767) - 16384), 16'($urandom_range(0, 32767) - 16384),
            16'($urandom_range(0, 32767) - 16384)};
  endfunction

  typedef struct {
    in_t p;
    bit fixed;
    out_t r;
  } row_t;

  initial begin
    row_t rows[$];
    in_t p;
    int burst;
    pose.head_axis_x = 48'd16384;
    pose.head_axis_y = 48'd1073741824;
    pose.head_axis_z = 48'd70368744177664;
    pose.head_origin = '0;
    pose.pan_half_tolerance = 15'd2458;
    pose.tilt_half_tolerance = 15'd2458;
    pose.cost_scale = 16'd33704;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // origin gives zero cost; straight ahead also zero
    rows = {rows, row_t'{mk(0, 0, 0), 1, res(0, 0, 0)}};
    rows = {rows, row_t'{mk(1000, 0, 0), 1, res(0, 0, 0)}};
    rows = {rows, row_t'{mk(32767, 0, 0), 0, '0}};
    rows = {rows, row_t'{mk(-32768, 0, 0), 0, '0}};
    rows = {rows, row_t'{mk(0, 32767, 0), 0, '0}};
    rows = {rows, row_t'{mk(0, -32768, 0), 0, '0}};
    rows = {rows, row_t'{mk(0, 0, 32767), 0, '0}};
    rows = {rows, row_t'{mk(0, 0, -32768), 0, '0}};
    rows = {rows, row_t'{mk(-1, 0, 0), 0, '0}};
    rows = {rows, row_t'{mk(-1, 1, 0), 0, '0}};
    rows = {rows, row_t'{mk(-1, -1, 1), 0, '0}};
    rows = {rows, row_t'{mk(32767, 32767, 32767), 0, '0}};
    rows = {rows, row_t'{mk(-32768, -32768, -32768), 0, '0}};
    rows = {rows, row_t'{mk(-21846, 21845, -1), 0, '0}};
    foreach (rows[i]) send_point(rows[i].p, rows[i].fixed, rows[i].r);
    in_valid <= 0;
    drain();

    // extreme settings: opposite axes, far origin, maximum pan and zero tilt tolerance, full scale
    write_reg(REG_AXIS_X, 64'hFFFF_8000_8000_8000);
    write_reg(REG_AXIS_Y, 64'h0000_7FFF_7FFF_7FFF);
    write_reg(REG_AXIS_Z, 64'h0000_8000_7FFF_8000);
    write_reg(REG_ORIGIN, 64'h0000_7FFF_8000_7FFF);
    write_reg(REG_PAN_TOL, 64'd32767);
    write_reg(REG_TILT_TOL, 64'd0);
    write_reg(REG_COST_SCALE, 64'd65535);
    send_point(mk(32767, -32768, 32767), 0, '0);
    send_point(mk(-32768, 32767, -32768), 0, '0);
    send_point(mk(0, 0, 0), 0, '0);
    send_point(mk(5, -7, 3), 0, '0);
    in_valid <= 0;
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_AXIS_X, phase == 0 ? 64'd16384 : {16'h0, rand_axis()});
      write_reg(REG_AXIS_Y, phase == 0 ? 64'd1073741824 : {16'h0, rand_axis()});
      write_reg(REG_AXIS_Z, phase == 0 ? 64'd70368744177664 : {16'h0, rand_axis()});
      write_reg(REG_ORIGIN, {16'h0, 48'($urandom) ^ (48'($urandom) << 32)});
      write_reg(REG_PAN_TOL, phase == 1 ? 64'd0 : 64'($urandom_range(0, 32767)));
      write_reg(REG_TILT_TOL, phase == 2 ? 64'd25736 : 64'($urandom_range(0, 25736)));
      write_reg(REG_COST_SCALE, phase == 3 ? 64'd0 : 64'($urandom_range(0, 65535)));
      for (int n = 0; n < 170;) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < 170; b++, n++) begin
          case ($urandom_range(0, 3))
            0: p = mk($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                      $urandom_range(0, 400) - 200);
            default: p = mk($urandom, $urandom, $urandom);
          endcase
          send_point(p, 0, '0);
        end
        in_valid <= 0;
        if (phase == 2 && n >= 80 && n - burst < 80) begin
          stall_hold = 1;
          while (cost_queue.size() != 0) @(posedge clk);
          stall_hold = 0;
        end
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      in_valid <= 0;
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
